@@ sv/ita_pkg.sv @@
// Shared types, codes and constants for the integer to ASCII converter.
package ita_pkg;

    // Default configuration
    localparam int MAX_WIDTH_DEF  = 32;
    localparam int VALUE_BITS_DEF = 64;

    // Radix codes on the kind field
    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_HEX = 2'd1;
    localparam logic [1:0] KIND_OCT = 2'd2;

    // Character codes
    localparam logic [6:0] CH_ZERO    = 7'd48;
    localparam logic [6:0] CH_A_LOWER = 7'd97;
    localparam logic [6:0] CH_SPACE   = 7'd32;
    localparam logic [6:0] CH_TEN     = 7'd10;

    // Operations on the digit shift register
    typedef enum logic [2:0] {
        DOP_HOLD,
        DOP_LOAD_DEC,
        DOP_LOAD_HEX,
        DOP_LOAD_OCT,
        DOP_DABBLE,
        DOP_SHIFT
    } dig_op_t;

    // Map one digit to its ASCII character
    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10)
            c = CH_ZERO + {3'b000, d};
        else
            c = CH_A_LOWER + {3'b000, d} - CH_TEN;
        return c;
    endfunction

endpackage

@@ sv/ita_digits.sv @@
// Digit shift register: decimal double dabble, hex and octal load, top-digit shift.
module ita_digits #(
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic            clk,
    input  ita_pkg::dig_op_t op,
    input  logic [63:0]     value,
    output logic [3:0]      top_digit
);
    import ita_pkg::*;

    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int WB   = 4 * NDIG;

    logic [3:0]            dig_reg [NDIG];
    logic [3:0]            dig_next [NDIG];
    logic [3:0]            adj [NDIG];
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic [WB-1:0]         wide;

    assign wide      = WB'(value[VALUE_BITS-1:0]);
    assign top_digit = dig_reg[NDIG-1];

    // Add three to every digit of five or more before each shift
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            adj[i] = (dig_reg[i] >= 4'd5) ? dig_reg[i] + 4'd3 : dig_reg[i];
        end
    end

    // Select the next digit contents
    always_comb
    begin
        val_next = val_reg;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_next[i] = dig_reg[i];
        end
        unique case (op)
            DOP_HOLD:
            begin
            end
            DOP_LOAD_DEC:
            begin
                val_next = value[VALUE_BITS-1:0];
                for (int i = 0; i < NDIG; i++)
                begin
                    dig_next[i] = 4'd0;
                end
            end
            DOP_LOAD_HEX:
            begin
                for (int i = 0; i < NDIG; i++)
                begin
                    dig_next[i] = wide[4*i +: 4];
                end
            end
            DOP_LOAD_OCT:
            begin
                for (int i = 0; i < NDIG; i++)
                begin
                    dig_next[i] = {1'b0, wide[3*i +: 3]};
                end
            end
            DOP_DABBLE:
            begin
                val_next = {val_reg[VALUE_BITS-2:0], 1'b0};
                dig_next[0] = {adj[0][2:0], val_reg[VALUE_BITS-1]};
                for (int i = 1; i < NDIG; i++)
                begin
                    dig_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
            end
            DOP_SHIFT:
            begin
                dig_next[0] = 4'd0;
                for (int i = 1; i < NDIG; i++)
                begin
                    dig_next[i] = dig_reg[i-1];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold digits and the value shift line
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        for (int i = 0; i < NDIG; i++)
        begin
            dig_reg[i] <= dig_next[i];
        end
    end

endmodule

@@ sv/integer_to_ascii_padded.sv @@
// Top level of the padded integer to ASCII converter: sequencer and output register.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------
//  in      | in_valid in_ready kind value zero_fill     | in_valid && in_ready
//          | min_width                                  |
//  out     | out_valid out_ready char_out last          | out_valid && out_ready
//
// One item at a time. Decimal runs one double-dabble step per value bit; hex and
// octal load their digits directly. A scan then drops leading zero digits, one per
// cycle (up to NDIG-1), and emission sends one character per cycle while the
// output is not stalled.
// Reset clears the sequencer, its counters and the output register. A stalled
// output holds the sequencer in emission; in_ready is high only between items.
module integer_to_ascii_padded #(
    parameter int MAX_WIDTH  = ita_pkg::MAX_WIDTH_DEF,
    parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [63:0] value,
    input  logic        zero_fill,
    input  logic [5:0]  min_width,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  char_out,
    output logic        last
);
    import ita_pkg::*;

    localparam int NDIG = (VALUE_BITS + 2) / 3;
    localparam int NW   = $clog2(NDIG + 1);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int BW   = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t      state_reg, state_next;
    logic [NW-1:0] ndig_reg, ndig_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] w_reg, w_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic        pad_zero_reg, pad_zero_next;
    logic        out_valid_reg, out_valid_next;
    logic [6:0]  char_reg, char_next;
    logic        last_reg, last_next;
    dig_op_t     op;
    logic [3:0]  top_digit;
    logic        in_fire;
    logic        emit_go;
    logic        pad_now;
    logic [CW-1:0] ndig_ext;
    logic [6:0]  pad_char;

    ita_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digits (
        .clk      (clk),
        .op       (op),
        .value    (value),
        .top_digit(top_digit)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;
    assign ndig_ext  = CW'(ndig_reg);
    assign emit_go   = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    assign pad_now   = rem_reg > ndig_ext;
    assign pad_char  = pad_zero_reg ? CH_ZERO : CH_SPACE;

    // Sequence conversion, scan and emission
    always_comb
    begin
        state_next     = state_reg;
        ndig_next      = ndig_reg;
        rem_next       = rem_reg;
        w_next         = w_reg;
        bit_next       = bit_reg;
        pad_zero_next  = pad_zero_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        op             = DOP_HOLD;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pad_zero_next = zero_fill;
                    w_next = ({1'b0, min_width} > 7'(MAX_WIDTH)) ?
                             CW'(MAX_WIDTH) : CW'(min_width);
                    bit_next  = BW'(VALUE_BITS - 1);
                    ndig_next = NW'(NDIG);
                    priority if (kind == KIND_HEX)
                    begin
                        op = DOP_LOAD_HEX;
                        state_next = ST_SCAN;
                    end
                    else if (kind == KIND_OCT)
                    begin
                        op = DOP_LOAD_OCT;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        op = DOP_LOAD_DEC;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                op = DOP_DABBLE;
                bit_next = bit_reg - BW'(1);
                if (bit_reg == '0)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((ndig_reg > NW'(1)) && (top_digit == 4'd0))
                begin
                    op = DOP_SHIFT;
                    ndig_next = ndig_reg - NW'(1);
                end
                else
                begin
                    rem_next = (w_reg > ndig_ext) ? w_reg : ndig_ext;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    last_next = (rem_reg == CW'(1));
                    rem_next = rem_reg - CW'(1);
                    if (pad_now)
                        char_next = pad_char;
                    else
                    begin
                        char_next = digit_char(top_digit);
                        op = DOP_SHIFT;
                        ndig_next = ndig_reg - NW'(1);
                    end
                    if (rem_reg == CW'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, counters and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ndig_reg      <= '0;
            rem_reg       <= '0;
            w_reg         <= '0;
            bit_reg       <= '0;
            pad_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ndig_reg      <= ndig_next;
            rem_reg       <= rem_next;
            w_reg         <= w_next;
            bit_reg       <= bit_next;
            pad_zero_reg  <= pad_zero_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    // Digit count stays within the store while an item is in flight
    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_EMIT)) |->
        ((ndig_reg <= NW'(NDIG)) && ((ndig_reg != '0) || (rem_reg == '0))))
        else $error("digit count out of range");

    // Remaining characters never fall below remaining digits
    a_rem_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (ndig_ext <= rem_reg))
        else $error("fewer characters left than digits");

    // An accepted item closes the input until its run ends
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input reopened during conversion");

    // The final character carries last and returns to idle
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && (rem_reg == CW'(1))) |=>
        (out_valid && last && (state_reg == ST_IDLE)))
        else $error("run did not end on last character");

endmodule

@@ bench/testbench.sv @@
// Testbench for the padded integer to ASCII converter: directed table, random items, checker.
`timescale 1ns / 1ps

module testbench;
    import ita_pkg::*;

    // Spare radix code, handled as decimal
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int DIR_N      = 18;
    localparam int RAND_N     = 102;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_WAIT = 150;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] value;
        logic        zero_fill;
        logic [5:0]  min_width;
    } num_req_t;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_exp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_DEC;
    logic [63:0] value = '0;
    logic        zero_fill = 1'b0;
    logic [5:0]  min_width = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  char_out;
    logic        last;

    // Typed expectation for the number on the input port; empty means predicted
    string       req_text = "";

    char_exp_t   chars_pending[$];
    num_req_t    dir_rows [DIR_N];
    string       dir_text [DIR_N];

    int          errors = 0;
    int          nums_taken = 0;
    int          chars_seen = 0;
    int          kind_count [4] = '{0, 0, 0, 0};
    int          idle_cycles = 0;
    int          ready_hold = 0;
    logic        out_calm = 1'b0;

    integer_to_ascii_padded uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .zero_fill (zero_fill),
        .min_width (min_width),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last)
    );

    always #1 clk = ~clk;

    // Work out the character run for one number and queue it
    task automatic predict_chars(input logic [1:0] k, input logic [63:0] v,
                                 input logic zf, input logic [5:0] mw);
        logic [6:0]  digs [0:63];
        logic [63:0] rest;
        logic [63:0] radix;
        logic [63:0] d;
        logic [6:0]  pad;
        int          ndig;
        int          width;
        int          total;
        int          from_end;
        char_exp_t   e;
        begin
            if (k == KIND_HEX)
                radix = 64'd16;
            else if (k == KIND_OCT)
                radix = 64'd8;
            else
                radix = 64'd10;
            rest = v & ({64{1'b1}} >> (64 - VALUE_BITS_DEF));
            pad = zf ? CH_ZERO : CH_SPACE;
            ndig = 0;
            // Peel digits, least significant first; zero still gives one digit
            while (ndig == 0 || rest != 0)
            begin
                d = rest % radix;
                digs[ndig] = (d < 64'd10) ? CH_ZERO + d[6:0] : CH_A_LOWER + d[6:0] - CH_TEN;
                rest = rest / radix;
                ndig++;
            end
            width = (int'(mw) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(mw);
            total = (width > ndig) ? width : ndig;
            for (int i = 0; i < total; i++)
            begin
                from_end = total - 1 - i;
                e.ch = (from_end < ndig) ? digs[from_end] : pad;
                e.last = (i == total - 1);
                chars_pending.push_back(e);
            end
        end
    endtask

    // Queue a run typed in by hand
    task automatic queue_text(input string s);
        char_exp_t e;
        begin
            for (int i = 0; i < s.len(); i++)
            begin
                e.ch = 7'(s[i]);
                e.last = (i == s.len() - 1);
                chars_pending.push_back(e);
            end
        end
    endtask

    // Record accepted numbers, check every character transfer
    always @(posedge clk)
    begin
        char_exp_t e;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                nums_taken++;
                kind_count[kind]++;
                if (req_text.len() != 0)
                    queue_text(req_text);
                else
                    predict_chars(kind, value, zero_fill, min_width);
            end
            if (out_valid && out_ready)
            begin
                chars_seen++;
                if (chars_pending.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected character: expected none, got %h last %b",
                             $time, char_out, last);
                end
                else
                begin
                    e = chars_pending.pop_front();
                    if (char_out !== e.ch)
                    begin
                        errors++;
                        $display("%0t: char_out mismatch: expected %h, got %h",
                                 $time, e.ch, char_out);
                    end
                    if (last !== e.last)
                    begin
                        errors++;
                        $display("%0t: last mismatch: expected %b, got %b",
                                 $time, e.last, last);
                    end
                end
            end
        end
    end

    // Stall the output side between character transfers
    always @(posedge clk)
    begin
        int stall;
        if (rst_n)
        begin
            if (out_ready && out_valid)
            begin
                if ($urandom_range(0, 39) == 0)
                    out_calm <= ~out_calm;
                stall = out_calm ? 0 : $urandom_range(0, 12);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    ready_hold <= stall - 1;
                end
            end
            else if (!out_ready)
            begin
                if (ready_hold == 0)
                    out_ready <= 1'b1;
                else
                    ready_hold <= ready_hold - 1;
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Drive the directed table, then random numbers, then drain
    initial
    begin
        num_req_t r;
        string    t;
        int       gap;
        logic     in_calm;
        in_calm = 1'b0;

        dir_rows[0]  = '{KIND_DEC,   64'd0,                     1'b0, 6'd0};
        dir_text[0]  = "0";
        dir_rows[1]  = '{KIND_DEC,   64'd0,                     1'b1, 6'd5};
        dir_text[1]  = "00000";
        dir_rows[2]  = '{KIND_DEC,   64'd0,                     1'b0, 6'd5};
        dir_text[2]  = "    0";
        dir_rows[3]  = '{KIND_DEC,   64'hffff_ffff_ffff_ffff,   1'b0, 6'd0};
        dir_text[3]  = "18446744073709551615";
        dir_rows[4]  = '{KIND_HEX,   64'hffff_ffff_ffff_ffff,   1'b0, 6'd0};
        dir_text[4]  = "ffffffffffffffff";
        dir_rows[5]  = '{KIND_OCT,   64'hffff_ffff_ffff_ffff,   1'b1, 6'd0};
        dir_text[5]  = "1777777777777777777777";
        dir_rows[6]  = '{KIND_HEX,   64'hdead_beef,             1'b1, 6'd12};
        dir_text[6]  = "0000deadbeef";
        dir_rows[7]  = '{KIND_OCT,   64'd8,                     1'b0, 6'd1};
        dir_text[7]  = "10";
        dir_rows[8]  = '{KIND_SPARE, 64'd12345,                 1'b0, 6'd3};
        dir_text[8]  = "12345";
        dir_rows[9]  = '{KIND_DEC,   64'd255,                   1'b1, 6'd32};
        dir_text[9]  = "";
        dir_rows[10] = '{KIND_HEX,   64'habc,                   1'b0, 6'd63};
        dir_text[10] = "";
        dir_rows[11] = '{KIND_OCT,   64'o777,                   1'b1, 6'd33};
        dir_text[11] = "";
        dir_rows[12] = '{KIND_DEC,   64'd1,                     1'b1, 6'd1};
        dir_text[12] = "1";
        dir_rows[13] = '{KIND_HEX,   64'h0123_4567_89ab_cdef,   1'b0, 6'd0};
        dir_text[13] = "123456789abcdef";
        dir_rows[14] = '{KIND_DEC,   64'd10000000000000000000,  1'b1, 6'd20};
        dir_text[14] = "10000000000000000000";
        dir_rows[15] = '{KIND_HEX,   64'h8000_0000_0000_0000,   1'b1, 6'd17};
        dir_text[15] = "08000000000000000";
        dir_rows[16] = '{KIND_OCT,   64'd1,                     1'b0, 6'd0};
        dir_text[16] = "1";
        dir_rows[17] = '{KIND_DEC,   64'd9,                     1'b0, 6'd2};
        dir_text[17] = " 9";

        // Hold reset, then release on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIR_N + RAND_N; n++)
        begin
            if (n < DIR_N)
            begin
                r = dir_rows[n];
                t = dir_text[n];
            end
            else
            begin
                r.kind = ($urandom_range(0, 9) == 0) ? KIND_SPARE : 2'($urandom_range(0, 2));
                case ($urandom_range(0, 4))
                    0: r.value = {$urandom, $urandom};
                    1: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
                    2: r.value = 64'($urandom_range(0, 1000));
                    3: r.value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
                    default: r.value = {$urandom, $urandom} >> $urandom_range(32, 63);
                endcase
                r.zero_fill = 1'($urandom_range(0, 1));
                r.min_width = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(25, 63))
                                                          : 6'($urandom_range(0, 24));
                t = "";
            end

            // Present the number and hold it until the transfer
            in_valid  <= 1'b1;
            kind      <= r.kind;
            value     <= r.value;
            zero_fill <= r.zero_fill;
            min_width <= r.min_width;
            req_text  <= t;
            @(posedge clk);
            while (!in_ready) @(posedge clk);

            // Draw the gap before the next number
            if ($urandom_range(0, 15) == 0)
                in_calm = ~in_calm;
            gap = in_calm ? 0 : $urandom_range(0, 12);
            if (gap > 0 || n == DIR_N + RAND_N - 1)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // Drain outstanding characters, then watch for strays
        while (chars_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d numbers into %0d characters", nums_taken, chars_seen);
        $display("Radix mix: %0d decimal, %0d hex, %0d octal, %0d spare code",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
